@@ rtl/cpc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared widths, codes, reset values and bundle types of the PID controller.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int MEAS_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 17;
    localparam int INTEG_W    = 24;
    localparam int DRIVE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int PROD_P_W = GAIN_W + ERR_W;
    localparam int PROD_I_W = GAIN_W + INTEG_W;
    localparam int PROD_D_W = GAIN_W + ERR_W;
    localparam int SUM_W    = PROD_I_W + 2;
    localparam int FRAC_W   = 8;
    localparam int SHIFT_W  = SUM_W - FRAC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT     = 3'd0,
        REG_GAIN_P       = 3'd1,
        REG_GAIN_I       = 3'd2,
        REG_GAIN_D       = 3'd3,
        REG_ERROR_MIN    = 3'd4,
        REG_ERROR_MAX    = 3'd5,
        REG_INTEGRAL_MIN = 3'd6,
        REG_INTEGRAL_MAX = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_CLEAR  = 1'b1
    } cmd_t;

    localparam logic signed [ERR_W-1:0]   ERROR_MIN_RST    = -17'sd500;
    localparam logic signed [ERR_W-1:0]   ERROR_MAX_RST    = 17'sd500;
    localparam logic signed [INTEG_W-1:0] INTEGRAL_MIN_RST = -24'sd500;
    localparam logic signed [INTEG_W-1:0] INTEGRAL_MAX_RST = 24'sd500;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [MEAS_W-1:0]  setpoint;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [ERR_W-1:0]   error_min;
        logic signed [ERR_W-1:0]   error_max;
        logic signed [INTEG_W-1:0] integral_min;
        logic signed [INTEG_W-1:0] integral_max;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [ERR_W-1:0]   deriv;
    } terms_t;

    typedef struct packed {
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
    } prods_t;

endpackage

@@ rtl/cpc_sample_if.sv @@
// ----------------------------------------------------------------------------
// cpc_sample_if
// Sample channel: command and measurement word with valid/ready.
// ----------------------------------------------------------------------------
interface cpc_sample_if
    import cpc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [MEAS_W-1:0] measurement;

    modport source (output valid, output cmd, output measurement, input ready);
    modport sink   (input valid, input cmd, input measurement, output ready);
endinterface

@@ rtl/cpc_result_if.sv @@
// ----------------------------------------------------------------------------
// cpc_result_if
// Result channel: drive word with valid/ready.
// ----------------------------------------------------------------------------
interface cpc_result_if
    import cpc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

@@ rtl/cpc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// cpc_cfg_if
// Configuration write channel: register index and data word with valid/ready.
// ----------------------------------------------------------------------------
interface cpc_cfg_if
    import cpc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/cpc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// cpc_cfg_regs
// Configuration register file: setpoint, gains and clamp limits.
// ----------------------------------------------------------------------------
module cpc_cfg_regs
    import cpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cpc_cfg_if.sink   cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_SETPOINT:     regs_next.setpoint     = $signed(cfg.data[MEAS_W-1:0]);
                REG_GAIN_P:       regs_next.gain_p       = $signed(cfg.data[GAIN_W-1:0]);
                REG_GAIN_I:       regs_next.gain_i       = $signed(cfg.data[GAIN_W-1:0]);
                REG_GAIN_D:       regs_next.gain_d       = $signed(cfg.data[GAIN_W-1:0]);
                REG_ERROR_MIN:    regs_next.error_min    = $signed(cfg.data[ERR_W-1:0]);
                REG_ERROR_MAX:    regs_next.error_max    = $signed(cfg.data[ERR_W-1:0]);
                REG_INTEGRAL_MIN: regs_next.integral_min = $signed(cfg.data[INTEG_W-1:0]);
                REG_INTEGRAL_MAX: regs_next.integral_max = $signed(cfg.data[INTEG_W-1:0]);
                default:          regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.setpoint     <= '0;
            regs_reg.gain_p       <= '0;
            regs_reg.gain_i       <= '0;
            regs_reg.gain_d       <= '0;
            regs_reg.error_min    <= ERROR_MIN_RST;
            regs_reg.error_max    <= ERROR_MAX_RST;
            regs_reg.integral_min <= INTEGRAL_MIN_RST;
            regs_reg.integral_max <= INTEGRAL_MAX_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ rtl/cpc_state_stage.sv @@
// ----------------------------------------------------------------------------
// cpc_state_stage
// Input register, clamped error, clamped integral and derivative; holds the
// integral and previous measurement state.
// ----------------------------------------------------------------------------
module cpc_state_stage
    import cpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        regs,
    cpc_sample_if.sink  sample,
    output logic        terms_valid,
    input  logic        terms_ready,
    output terms_t      terms
);

    logic                      in_valid_reg;
    logic                      in_valid_next;
    cmd_t                      cmd_reg;
    logic signed [MEAS_W-1:0]  meas_reg;

    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [MEAS_W-1:0]  prev_reg;
    logic signed [MEAS_W-1:0]  prev_next;

    logic                      terms_valid_reg;
    logic                      terms_valid_next;
    terms_t                    terms_reg;
    terms_t                    terms_next;

    logic                      out_free;
    logic                      fire;
    logic                      do_sample;
    logic signed [ERR_W-1:0]   err_raw;
    logic signed [ERR_W-1:0]   err_c;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_c;
    logic signed [ERR_W-1:0]   deriv;

    assign out_free     = !terms_valid_reg || terms_ready;
    assign fire         = in_valid_reg && out_free;
    assign do_sample    = fire && (cmd_reg == CMD_SAMPLE);
    assign sample.ready = !in_valid_reg || out_free;
    assign terms_valid  = terms_valid_reg;
    assign terms        = terms_reg;

    // lower limit tested first, so crossed limits resolve the same way
    always_comb
    begin
        err_raw = ERR_W'(regs.setpoint) - ERR_W'(meas_reg);
        if (err_raw < regs.error_min)
            err_c = regs.error_min;
        else if (err_raw > regs.error_max)
            err_c = regs.error_max;
        else
            err_c = err_raw;

        integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err_c);
        if (integ_sum < regs.integral_min)
            integ_c = regs.integral_min;
        else if (integ_sum > regs.integral_max)
            integ_c = regs.integral_max;
        else
            integ_c = INTEG_W'(integ_sum);

        deriv = ERR_W'(prev_reg) - ERR_W'(meas_reg);
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (sample.valid && sample.ready)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        integ_next = integ_reg;
        prev_next  = prev_reg;
        if (fire && (cmd_reg == CMD_CLEAR))
            integ_next = '0;
        else if (do_sample)
        begin
            integ_next = integ_c;
            prev_next  = meas_reg;
        end

        terms_valid_next = terms_valid_reg && !terms_ready;
        terms_next       = terms_reg;
        if (do_sample)
        begin
            terms_valid_next = 1'b1;
            terms_next.err   = err_c;
            terms_next.integ = integ_c;
            terms_next.deriv = deriv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            terms_valid_reg <= 1'b0;
            integ_reg       <= '0;
            prev_reg        <= '0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            terms_valid_reg <= terms_valid_next;
            integ_reg       <= integ_next;
            prev_reg        <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            cmd_reg  <= cmd_t'(sample.cmd);
            meas_reg <= sample.measurement;
        end
        terms_reg <= terms_next;
    end

endmodule

@@ rtl/cpc_mult_stage.sv @@
// ----------------------------------------------------------------------------
// cpc_mult_stage
// Gain multiplies of the error, integral and derivative terms.
// ----------------------------------------------------------------------------
module cpc_mult_stage
    import cpc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   regs,
    input  logic   terms_valid,
    output logic   terms_ready,
    input  terms_t terms,
    output logic   prods_valid,
    input  logic   prods_ready,
    output prods_t prods
);

    logic   prods_valid_reg;
    logic   prods_valid_next;
    prods_t prods_reg;
    prods_t prods_next;
    logic   load;

    assign terms_ready = !prods_valid_reg || prods_ready;
    assign load        = terms_valid && terms_ready;
    assign prods_valid = prods_valid_reg;
    assign prods       = prods_reg;

    always_comb
    begin
        prods_valid_next = prods_valid_reg && !prods_ready;
        prods_next       = prods_reg;
        if (load)
        begin
            prods_valid_next  = 1'b1;
            prods_next.prod_p = PROD_P_W'(regs.gain_p) * PROD_P_W'(terms.err);
            prods_next.prod_i = PROD_I_W'(regs.gain_i) * PROD_I_W'(terms.integ);
            prods_next.prod_d = PROD_D_W'(regs.gain_d) * PROD_D_W'(terms.deriv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prods_valid_reg <= 1'b0;
        else
            prods_valid_reg <= prods_valid_next;
    end

    always_ff @(posedge clk)
    begin
        prods_reg <= prods_next;
    end

endmodule

@@ rtl/cpc_sum_stage.sv @@
// ----------------------------------------------------------------------------
// cpc_sum_stage
// Product sum, Q8.8 scale-down by arithmetic shift, 32-bit saturation and
// output register.
// ----------------------------------------------------------------------------
module cpc_sum_stage
    import cpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         prods_valid,
    output logic         prods_ready,
    input  prods_t       prods,
    cpc_result_if.source result
);

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic                      load;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SHIFT_W-1:0] shifted;
    logic signed [DRIVE_W-1:0] sat;

    assign prods_ready  = !valid_reg || result.ready;
    assign load         = prods_valid && prods_ready;
    assign result.valid = valid_reg;
    assign result.drive = drive_reg;

    always_comb
    begin
        sum = SUM_W'(prods.prod_p) + SUM_W'(prods.prod_i) + SUM_W'(prods.prod_d);
        shifted = $signed(sum[SUM_W-1:FRAC_W]);
        // fits when all bits above the drive's sign bit match it
        if (shifted[SHIFT_W-1:DRIVE_W-1] == '0 || shifted[SHIFT_W-1:DRIVE_W-1] == '1)
            sat = shifted[DRIVE_W-1:0];
        else if (shifted[SHIFT_W-1])
            sat = DRIVE_MIN;
        else
            sat = DRIVE_MAX;
    end

    always_comb
    begin
        valid_next = valid_reg && !result.ready;
        drive_next = drive_reg;
        if (load)
        begin
            valid_next = 1'b1;
            drive_next = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        drive_reg <= drive_next;
    end

endmodule

@@ rtl/clamped_pid_controller_core.sv @@
// ----------------------------------------------------------------------------
// clamped_pid_controller_core
// PID controller with clamped error and clamped integral, Q8.8 gains and a
// saturated 32-bit drive word.
//
//   channel  dir   word                         handshake
//   sample   in    cmd, measurement[15:0]       valid/ready
//   result   out   drive[31:0]                  valid/ready
//   cfg      in    index[2:0], data[23:0]       valid/ready, ready tied high
//
// One sample word per cycle unless the result stalls; drive is valid once the
// word passes the input, term, product and output registers in that order.
// Integral and previous measurement live in the term stage and update as a
// word leaves the input register; a clear word updates state only.
// Each stage holds its word while the next is full, so a stalled result
// backs up stage by stage. Reset clears state, valid flags, default limits.
// ----------------------------------------------------------------------------
module clamped_pid_controller_core
    import cpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cpc_sample_if.sink   sample,
    cpc_result_if.source result,
    cpc_cfg_if.sink      cfg
);

    cfg_t   regs;
    logic   terms_valid;
    logic   terms_ready;
    terms_t terms;
    logic   prods_valid;
    logic   prods_ready;
    prods_t prods;

    cpc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    cpc_state_stage u_state_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .regs        (regs),
        .sample      (sample),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms)
    );

    cpc_mult_stage u_mult_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .regs        (regs),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms),
        .prods_valid (prods_valid),
        .prods_ready (prods_ready),
        .prods       (prods)
    );

    cpc_sum_stage u_sum_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .prods_valid (prods_valid),
        .prods_ready (prods_ready),
        .prods       (prods),
        .result      (result)
    );

endmodule
